// ----- hw/rtl/clw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types and constants for the character LCD cursor writer.
// ----------------------------------------------------------------------------
package clw_pkg;

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_GOTO   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] ROW0_BASE      = 8'h80;
  localparam logic [7:0] ROW1_BASE      = 8'hC0;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [5:0] COLUMNS_RESET  = 6'd16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // up to three bytes per transaction, each with its own register select
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [2:0]      rs;
    logic [1:0]      count;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  function automatic logic [7:0] set_address(input logic [1:0] r, input logic [5:0] c,
                                             input logic [5:0] cols);
    logic [7:0] base;
    case (r)
      2'd0:    base = ROW0_BASE;
      2'd1:    base = ROW1_BASE;
      2'd2:    base = ROW0_BASE + {2'b00, cols};
      default: base = ROW1_BASE + {2'b00, cols};
    endcase
    return base + {2'b00, c};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/clw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_front
// Accepts commands, tracks the cursor and builds the byte list for each one.
// ----------------------------------------------------------------------------
module clw_front import clw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       q_full,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] char_code,
  input  wire logic [5:0] column,
  input  wire logic [1:0] row,
  input  wire logic       write_enable,
  input  wire logic [5:0] columns_wdata,
  output logic            enq_valid,
  output job_t            enq_job
);

  logic [5:0] columns;
  logic [5:0] cursor_col;
  logic [1:0] cursor_row;
  logic [5:0] cursor_col_next;
  logic [1:0] cursor_row_next;
  logic [6:0] col_inc;
  logic       accept;
  logic       has_job;

  assign accept    = push && !q_full;
  assign enq_valid = accept && has_job;
  assign col_inc   = {1'b0, cursor_col} + 7'd1;

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    has_job         = 1'b1;
    enq_job         = '0;
    unique case (mode_t'(mode))
      MODE_PUT: begin
        if (char_code == CHAR_NEWLINE) begin
          cursor_row_next  = cursor_row + 2'd1;
          cursor_col_next  = 6'd0;
          enq_job.data[0]  = set_address(cursor_row_next, 6'd0, columns);
          enq_job.count    = 2'd1;
        end else if (col_inc > {1'b0, columns}) begin
          cursor_row_next  = cursor_row + 2'd1;
          cursor_col_next  = 6'd1;
          enq_job.data[0]  = set_address(cursor_row_next, 6'd0, columns);
          enq_job.data[1]  = char_code;
          enq_job.rs[1]    = 1'b1;
          enq_job.count    = 2'd2;
        end else begin
          cursor_col_next  = col_inc[5:0];
          enq_job.data[0]  = char_code;
          enq_job.rs[0]    = 1'b1;
          enq_job.count    = 2'd1;
        end
      end
      MODE_GOTO: begin
        cursor_col_next = column;
        cursor_row_next = row;
        enq_job.data[0] = set_address(row, column, columns);
        enq_job.count   = 2'd1;
      end
      MODE_CLEAR: begin
        cursor_col_next = 6'd0;
        cursor_row_next = 2'd0;
        enq_job.data[0] = CMD_HOME;
        enq_job.data[1] = CMD_DISPLAY_ON;
        enq_job.data[2] = CMD_CLEAR;
        enq_job.count   = 2'd3;
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= COLUMNS_RESET;
      cursor_col <= 6'd0;
      cursor_row <= 2'd0;
    end else begin
      if (write_enable) begin
        columns <= columns_wdata;
      end
      if (accept) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
    end
  end

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_CLEAR |=> cursor_col == 6'd0 && cursor_row == 2'd0)
    else $error("cursor not homed after clear");

endmodule
`default_nettype wire

// ----- hw/rtl/clw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_queue
// Short job queue between the command front and the nibble sequencer.
// ----------------------------------------------------------------------------
module clw_queue import clw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enq_valid,
  input  wire job_t enq_job,
  output logic      full,
  input  wire logic deq,
  output head_t     head
);

  job_t                store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_enq;
  logic                do_deq;

  assign full       = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = store[rd_ptr];
  assign do_enq     = enq_valid && !full;
  assign do_deq     = deq && head.valid;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      store[wr_ptr] <= enq_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_enq && !do_deq) begin
        count <= count + 1'b1;
      end else if (do_deq && !do_enq) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("job queue overflow");

endmodule
`default_nettype wire

// ----- hw/rtl/clw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_back
// Splits queued bytes into nibbles, high nibble first, into an output stage.
// ----------------------------------------------------------------------------
module clw_back import clw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire head_t head,
  output logic       deq,
  input  wire logic  pop,
  output logic       empty,
  output logic [3:0] nibble,
  output logic       reg_select,
  output logic       last
);

  logic [2:0] idx;
  logic [1:0] byte_sel;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       out_valid;
  logic       load;

  assign byte_sel = idx[2:1];
  assign cur_byte = head.job.data[byte_sel];
  assign cur_last = idx[0] && (byte_sel == head.job.count - 2'd1);
  assign load     = head.valid && (!out_valid || pop);
  assign deq      = load && cur_last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      nibble     <= idx[0] ? cur_byte[3:0] : cur_byte[7:4];
      reg_select <= head.job.rs[byte_sel];
      last       <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= cur_last ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> byte_sel < head.job.count)
    else $error("nibble index past end of job");

  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    deq |=> idx == 3'd0)
    else $error("nibble index not reset after job");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(nibble) && $stable(last))
    else $error("waiting nibble changed");

endmodule
`default_nettype wire

// ----- hw/rtl/char_lcd_cursor_writer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// accepted commands are queued, then the first nibble loads the output register
// throughput: one nibble per cycle while pop is high and jobs wait; a character
//   is 2 or 4 nibbles, a go-to or newline 2, and a clear 6; mode 3 makes none
// a two-entry job queue lets commands be taken while earlier ones drain
// reset: cursor at column 0 row 0, columns 16, queue and output empty
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer
// Cursor-tracking command writer for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
module char_lcd_cursor_writer import clw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] char_code,
  input  wire logic [5:0] column,
  input  wire logic [1:0] row,
  input  wire logic       write_enable,
  input  wire logic [5:0] columns,
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      nibble,
  output logic            reg_select,
  output logic            last
);

  logic  enq_valid;
  job_t  enq_job;
  head_t head;
  logic  deq;

  clw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (full),
    .mode          (mode),
    .char_code     (char_code),
    .column        (column),
    .row           (row),
    .write_enable  (write_enable),
    .columns_wdata (columns),
    .enq_valid     (enq_valid),
    .enq_job       (enq_job)
  );

  clw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (enq_valid),
    .enq_job   (enq_job),
    .full      (full),
    .deq       (deq),
    .head      (head)
  );

  clw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .deq        (deq),
    .pop        (pop),
    .empty      (empty),
    .nibble     (nibble),
    .reg_select (reg_select),
    .last       (last)
  );

endmodule
`default_nettype wire

// ----- bench/char_lcd_cursor_writer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer_tb
// Drives put, go-to, newline, clear and unused commands into the LCD cursor
// writer under several line widths with random push and pop idling. A cursor
// model predicts every nibble strobe, and each popped transaction is checked
// field by field in order.
// ----------------------------------------------------------------------------
module char_lcd_cursor_writer_tb import clw_pkg::*; ();

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       last;
  } bus_nibble_t;

  class lcd_bus_predictor;
    logic [5:0]  line_width;
    logic [5:0]  cur_col;
    logic [1:0]  cur_row;
    bus_nibble_t pending_nibbles[$];
    int          failures;

    function new();
      line_width = COLUMNS_RESET;
      cur_col    = '0;
      cur_row    = '0;
      failures   = 0;
    endfunction

    function void set_width(logic [5:0] w);
      line_width = w;
    endfunction

    function int outstanding();
      return pending_nibbles.size();
    endfunction

    function void queue_byte(logic [7:0] b, logic rs, logic is_last);
      bus_nibble_t n;
      n.nibble = b[7:4];
      n.rs     = rs;
      n.last   = 1'b0;
      pending_nibbles.push_back(n);
      n.nibble = b[3:0];
      n.last   = is_last;
      pending_nibbles.push_back(n);
    endfunction

    function void queue_address(logic is_last);
      logic [7:0] base;
      case (cur_row)
        2'd0:    base = ROW0_BASE;
        2'd1:    base = ROW1_BASE;
        2'd2:    base = ROW0_BASE + {2'b00, line_width};
        default: base = ROW1_BASE + {2'b00, line_width};
      endcase
      queue_byte(base + {2'b00, cur_col}, 1'b0, is_last);
    endfunction

    // cursor update and expected strobes for one accepted command
    function void take_command(mode_t m, logic [7:0] ch, logic [5:0] col, logic [1:0] r);
      logic [6:0] next_col;
      case (m)
        MODE_PUT: begin
          if (ch == CHAR_NEWLINE) begin
            cur_row = cur_row + 2'd1;
            cur_col = '0;
            queue_address(1'b1);
          end else begin
            next_col = {1'b0, cur_col} + 7'd1;
            if (next_col > {1'b0, line_width}) begin
              cur_row = cur_row + 2'd1;
              cur_col = '0;
              queue_address(1'b0);
              cur_col = 6'd1;
            end else begin
              cur_col = next_col[5:0];
            end
            queue_byte(ch, 1'b1, 1'b1);
          end
        end
        MODE_GOTO: begin
          cur_col = col;
          cur_row = r;
          queue_address(1'b1);
        end
        MODE_CLEAR: begin
          queue_byte(CMD_HOME, 1'b0, 1'b0);
          queue_byte(CMD_DISPLAY_ON, 1'b0, 1'b0);
          queue_byte(CMD_CLEAR, 1'b0, 1'b1);
          cur_col = '0;
          cur_row = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_nibble(logic [3:0] nib, logic rs, logic lst);
      bus_nibble_t want;
      if (pending_nibbles.size() == 0) begin
        $error("nibble %0h rs %0b last %0b popped with nothing expected", nib, rs, lst);
        failures++;
        return;
      end
      want = pending_nibbles.pop_front();
      if (nib !== want.nibble) begin
        $error("nibble: expected %0h, actual %0h", want.nibble, nib);
        failures++;
      end
      if (rs !== want.rs) begin
        $error("reg_select: expected %0b, actual %0b", want.rs, rs);
        failures++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, lst);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst          = 1'b1;
  logic       push         = 1'b0;
  logic       full;
  logic [1:0] mode         = '0;
  logic [7:0] char_code    = '0;
  logic [5:0] column       = '0;
  logic [1:0] row          = '0;
  logic       write_enable = 1'b0;
  logic [5:0] columns      = COLUMNS_RESET;
  logic       empty;
  logic       pop          = 1'b0;
  logic [3:0] nibble;
  logic       reg_select;
  logic       last;

  logic             idling = 1'b1;
  int               cycle_count = 0;
  lcd_bus_predictor pred = new();

  char_lcd_cursor_writer DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .char_code(char_code),
    .column(column),
    .row(row),
    .write_enable(write_enable),
    .columns(columns),
    .empty(empty),
    .pop(pop),
    .nibble(nibble),
    .reg_select(reg_select),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side
  initial begin
    wait (!rst);
    forever begin
      pop <= !idling || ($urandom_range(99) >= 31);
      @(posedge clk);
      if (pop && !empty) pred.check_nibble(nibble, reg_select, last);
    end
  end

  task automatic issue(mode_t m, logic [7:0] ch, logic [5:0] col, logic [1:0] r);
    while (idling && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    mode      <= m;
    char_code <= ch;
    column    <= col;
    row       <= r;
    do @(posedge clk); while (full);
    pred.take_command(m, ch, col, r);
  endtask

  task automatic put(logic [7:0] ch);
    issue(MODE_PUT, ch, 6'($urandom), 2'($urandom));
  endtask

  task automatic goto_pos(logic [5:0] col, logic [1:0] r);
    issue(MODE_GOTO, 8'($urandom), col, r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pred.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_line_width(logic [5:0] w);
    drain();
    write_enable <= 1'b1;
    columns      <= w;
    @(posedge clk);
    write_enable <= 1'b0;
    columns      <= 6'($urandom);
    pred.set_width(w);
  endtask

  // mostly text so the wrap logic is exercised, with go-to, clear and noise
  task automatic random_command(output bit counted);
    int         pick;
    logic [5:0] col;
    pick    = $urandom_range(99);
    counted = 1'b1;
    if (pick < 60) begin
      put(($urandom_range(9) == 0) ? CHAR_NEWLINE : 8'($urandom_range(255)));
    end else if (pick < 82) begin
      col = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(40));
      goto_pos(col, 2'($urandom));
    end else if (pick < 92) begin
      issue(MODE_CLEAR, 8'($urandom), 6'($urandom), 2'($urandom));
    end else begin
      issue(MODE_UNUSED, 8'($urandom), 6'($urandom), 2'($urandom));
      counted = 1'b0;
    end
  endtask

  initial begin
    logic [5:0] widths [6];
    bit         counted;
    int         n;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width of 16
    put(8'h41);
    put(8'hFF);
    put(8'h00);
    put(CHAR_NEWLINE);
    goto_pos(6'd15, 2'd0);
    put(8'h55);
    put(8'hAA);
    goto_pos(6'd40, 2'd3);
    put(CHAR_NEWLINE);
    goto_pos(6'd63, 2'd2);
    issue(MODE_UNUSED, 8'hFF, 6'd63, 2'd3);
    issue(MODE_CLEAR, 8'h00, 6'd0, 2'd0);

    // zero width wraps on every character
    set_line_width(6'd0);
    put(8'h30);
    put(8'h31);

    // widest register value, address byte wraps
    set_line_width(6'd63);
    goto_pos(6'd63, 2'd3);
    put(8'h7E);
    goto_pos(6'd0, 2'd1);

    set_line_width(6'd1);
    put(8'h61);
    put(8'h62);
    put(CHAR_NEWLINE);

    set_line_width(6'd40);
    goto_pos(6'd40, 2'd2);
    put(8'h80);
    issue(MODE_CLEAR, 8'hFF, 6'd63, 2'd3);

    widths = '{6'd16, 6'd40, 6'd1, 6'd0, 6'd63, 6'($urandom_range(2, 39))};
    foreach (widths[p]) begin
      set_line_width(widths[p]);
      idling = (p != 2);
      n = 0;
      while (n < 65) begin
        random_command(counted);
        if (counted) n++;
        if ($urandom_range(99) == 0) drain();
      end
    end
    idling = 1'b1;

    drain();
    repeat (8) @(posedge clk);
    if (pred.failures == 0 && pred.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
